@@ rtl/qat_pkg.sv @@
package qat_pkg;

  // default sizing
  localparam int unsigned BUFFER_BYTES_DEF = 4096;
  localparam int unsigned COUNT_BITS_DEF   = 16;

  // fixed field widths
  localparam int unsigned OFFSET_W = 12;
  localparam int unsigned INDEX_W  = 16;
  localparam int unsigned LIMIT_W  = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // special bytes
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_NUL       = 8'h00;

  typedef enum logic [1:0] {
    QUOTE_SINGLE = 2'd0,
    QUOTE_DOUBLE = 2'd1,
    QUOTE_NONE   = 2'd2
  } qmode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIMIT_ENABLE  = 2'd0,
    CFG_TOKEN_LIMIT   = 2'd1,
    CFG_INITIAL_COUNT = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic       escape_pending;
    qmode_e     quote_mode;
    logic       token_open;
    logic       failed;
  } flags_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]          out_byte;
    logic                token_done;
    logic [OFFSET_W-1:0] token_offset;
    logic [INDEX_W-1:0]  token_index;
    logic                overflow_error;
    logic                end_of_buffer;
  } result_t;

endpackage

@@ rtl/quoted_argument_tokenizer_unit.sv @@
// Command-line tokenizer: takes one buffer byte per beat and returns one result beat per
// byte, with the byte rewritten (unquoted separators zeroed, quoted zeros made spaces) and,
// when a non-empty token closes, its start offset and table slot. A byte is accepted in
// every cycle while in_stall_o is low; the parse-state update (escape, quote mode, open
// token, position, count) sets that rate. A two-beat output buffer lets input keep
// flowing for one beat while the output is stalled. The byte after a last_byte starts a
// new buffer and reloads the count from initial_count. The user must write configuration
// through cfg_we_i/cfg_index_i/cfg_wdata_i only while idle; the block does not check it.
module quoted_argument_tokenizer_unit #(
  parameter int unsigned BUFFER_BYTES = qat_pkg::BUFFER_BYTES_DEF,
  parameter int unsigned COUNT_BITS   = qat_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [qat_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [qat_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  qat_pkg::item_t                  in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output qat_pkg::result_t                out_data_o
);

  localparam int unsigned POS_BITS = $clog2(BUFFER_BYTES);

  // configuration registers
  logic                          limit_enable_q;
  logic [qat_pkg::LIMIT_W-1:0]   token_limit_q;
  logic [qat_pkg::CFG_W-1:0]     initial_count_q;

  // parse state
  qat_pkg::flags_t               flags_q, flags_d;
  logic                          at_start_q;
  logic [POS_BITS-1:0]           position_q, position_d;
  logic [POS_BITS-1:0]           token_begin_q, token_begin_d;
  logic [COUNT_BITS-1:0]         token_count_q, token_count_d;

  qat_pkg::result_t              result;
  logic                          in_accept;

  assign in_accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_enable_q  <= 1'b0;
      token_limit_q   <= '0;
      initial_count_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        qat_pkg::CFG_LIMIT_ENABLE:  limit_enable_q  <= cfg_wdata_i[0];
        qat_pkg::CFG_TOKEN_LIMIT:   token_limit_q   <= cfg_wdata_i[qat_pkg::LIMIT_W-1:0];
        qat_pkg::CFG_INITIAL_COUNT: initial_count_q <= cfg_wdata_i;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // per-byte state update
  qat_step #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .COUNT_BITS   (COUNT_BITS)
  ) u_step (
    .item_i          (in_data_i),
    .at_start_i      (at_start_q),
    .flags_i         (flags_q),
    .position_i      (position_q),
    .token_begin_i   (token_begin_q),
    .token_count_i   (token_count_q),
    .limit_enable_i  (limit_enable_q),
    .token_limit_i   (token_limit_q),
    .initial_count_i (initial_count_q),
    .flags_o         (flags_d),
    .position_o      (position_d),
    .token_begin_o   (token_begin_d),
    .token_count_o   (token_count_d),
    .result_o        (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q       <= '{escape_pending: 1'b0, quote_mode: qat_pkg::QUOTE_NONE,
                         token_open: 1'b0, failed: 1'b0};
      at_start_q    <= 1'b1;
      position_q    <= '0;
      token_begin_q <= '0;
      token_count_q <= '0;
    end else if (in_accept) begin
      flags_q       <= flags_d;
      at_start_q    <= in_data_i.last_byte;
      position_q    <= position_d;
      token_begin_q <= token_begin_d;
      token_count_q <= token_count_d;
    end
  end

  // result register with one spare beat
  qat_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (result),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // a closed token never coincides with a failed parse
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.token_done |-> !out_data_o.overflow_error)
    else $error("token close reported together with overflow");

  // offset and slot stay zero without a close
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.token_done |->
      out_data_o.token_offset == '0 && out_data_o.token_index == '0)
    else $error("stale token fields on a beat with no close");

  // failure is sticky within a buffer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && flags_q.failed && !at_start_q |=> flags_q.failed)
    else $error("failure flag dropped inside a buffer");

  // the beat after a last byte starts a new buffer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_data_i.last_byte |=> at_start_q)
    else $error("buffer start not armed after last byte");

  // with nothing buffered at the output the input side is open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with an empty output buffer");

endmodule

@@ rtl/qat_step.sv @@
module qat_step #(
  parameter int unsigned BUFFER_BYTES = qat_pkg::BUFFER_BYTES_DEF,
  parameter int unsigned COUNT_BITS   = qat_pkg::COUNT_BITS_DEF,
  localparam int unsigned POS_BITS    = $clog2(BUFFER_BYTES),
  localparam int unsigned CMP_W       =
    (COUNT_BITS > qat_pkg::LIMIT_W) ? COUNT_BITS : qat_pkg::LIMIT_W
) (
  input  qat_pkg::item_t                item_i,
  input  logic                          at_start_i,
  input  qat_pkg::flags_t               flags_i,
  input  logic [POS_BITS-1:0]           position_i,
  input  logic [POS_BITS-1:0]           token_begin_i,
  input  logic [COUNT_BITS-1:0]         token_count_i,
  input  logic                          limit_enable_i,
  input  logic [qat_pkg::LIMIT_W-1:0]   token_limit_i,
  input  logic [qat_pkg::CFG_W-1:0]     initial_count_i,
  output qat_pkg::flags_t               flags_o,
  output logic [POS_BITS-1:0]           position_o,
  output logic [POS_BITS-1:0]           token_begin_o,
  output logic [COUNT_BITS-1:0]         token_count_o,
  output qat_pkg::result_t              result_o
);

  localparam logic [POS_BITS-1:0] LAST_POS = POS_BITS'(BUFFER_BYTES - 1);

  always_comb begin
    logic                  esc;
    logic                  opn;
    logic                  fl;
    qat_pkg::qmode_e       qm;
    logic [POS_BITS-1:0]   pos;
    logic [POS_BITS-1:0]   tbeg;
    logic [POS_BITS-1:0]   np;
    logic [COUNT_BITS-1:0] cnt;
    logic [7:0]            b;
    logic                  done;
    logic [POS_BITS-1:0]   doff;
    logic [COUNT_BITS-1:0] didx;
    logic                  full;

    esc  = flags_i.escape_pending;
    qm   = flags_i.quote_mode;
    opn  = flags_i.token_open;
    fl   = flags_i.failed;
    pos  = position_i;
    tbeg = token_begin_i;
    cnt  = token_count_i;
    // a new buffer starts from clean parse state
    if (at_start_i) begin
      esc  = 1'b0;
      qm   = qat_pkg::QUOTE_NONE;
      opn  = 1'b0;
      fl   = 1'b0;
      pos  = '0;
      tbeg = '0;
      cnt  = COUNT_BITS'(initial_count_i);
    end

    np   = (pos == LAST_POS) ? '0 : pos + 1'b1;
    full = limit_enable_i && (CMP_W'(cnt) >= CMP_W'(token_limit_i));
    b    = item_i.byte_value;
    done = 1'b0;
    doff = '0;
    didx = '0;

    if (!fl) begin
      if (esc) begin
        esc = 1'b0;
        opn = 1'b1;
      end else if (b == qat_pkg::CH_BACKSLASH) begin
        esc = 1'b1;
        opn = 1'b1;
      end else if (b == qat_pkg::CH_SQUOTE && qm != qat_pkg::QUOTE_DOUBLE) begin
        qm  = (qm == qat_pkg::QUOTE_SINGLE) ? qat_pkg::QUOTE_NONE : qat_pkg::QUOTE_SINGLE;
        opn = 1'b1;
      end else if (b == qat_pkg::CH_DQUOTE && qm != qat_pkg::QUOTE_SINGLE) begin
        qm  = (qm == qat_pkg::QUOTE_DOUBLE) ? qat_pkg::QUOTE_NONE : qat_pkg::QUOTE_DOUBLE;
        opn = 1'b1;
      end else if (qm == qat_pkg::QUOTE_NONE) begin
        if (b == qat_pkg::CH_SPACE || b == qat_pkg::CH_NUL) begin
          b = qat_pkg::CH_NUL;
          // separator close
          if (opn && full) begin
            fl = 1'b1;
          end else begin
            if (opn) begin
              done = 1'b1;
              doff = tbeg;
              didx = cnt;
              if (cnt != '1) cnt = cnt + 1'b1;
            end
            opn  = 1'b0;
            tbeg = np;
          end
        end else begin
          opn = 1'b1;
        end
      end else begin
        if (b == qat_pkg::CH_NUL) b = qat_pkg::CH_SPACE;
        opn = 1'b1;
      end

      // implied terminator after the last byte
      if (item_i.last_byte && !fl && !esc && qm == qat_pkg::QUOTE_NONE) begin
        if (opn && full) begin
          fl = 1'b1;
        end else begin
          if (opn) begin
            done = 1'b1;
            doff = tbeg;
            didx = cnt;
            if (cnt != '1) cnt = cnt + 1'b1;
          end
          opn  = 1'b0;
          tbeg = '0;
        end
      end
    end

    flags_o.escape_pending  = esc;
    flags_o.quote_mode      = qm;
    flags_o.token_open      = opn;
    flags_o.failed          = fl;
    position_o              = np;
    token_begin_o           = tbeg;
    token_count_o           = cnt;
    result_o.out_byte       = b;
    result_o.token_done     = done;
    result_o.token_offset   = qat_pkg::OFFSET_W'(doff);
    result_o.token_index    = qat_pkg::INDEX_W'(didx);
    result_o.overflow_error = fl;
    result_o.end_of_buffer  = item_i.last_byte;
  end

endmodule

@@ rtl/qat_skid.sv @@
module qat_skid (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  qat_pkg::result_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output qat_pkg::result_t out_data_o
);

  logic             main_valid_q, main_valid_d;
  logic             skid_valid_q, skid_valid_d;
  qat_pkg::result_t main_q, main_d;
  qat_pkg::result_t skid_q, skid_d;
  logic             accept;
  logic             drain;

  assign in_stall_o  = skid_valid_q;
  assign accept      = in_valid_i && !skid_valid_q;
  assign drain       = !main_valid_q || !out_stall_i;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (drain) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        main_valid_d = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        main_d       = in_data_i;
        main_valid_d = accept;
      end
    end else if (accept) begin
      skid_d       = in_data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule
